/* hdl/rgb_led_serial_transmitter_macros.svh */
// ----------------------------------------------------------------------------
// rgb_led_serial_transmitter_macros.svh
// Assertion macros shared by the LED transmitter RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_SERIAL_TRANSMITTER_MACROS_SVH
`define RGB_LED_SERIAL_TRANSMITTER_MACROS_SVH

// Condition must hold on every clock outside reset.
`define RGBLED_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define RGBLED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rgbled_pkg.sv */
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared types and constants of the serial RGB LED transmitter.
// ----------------------------------------------------------------------------
package rgbled_pkg;

  localparam int TICK_BITS_DEFAULT   = 10;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int CHAN_W     = 8;
  localparam int WORD_W     = 24;
  localparam int GAIN_W     = 16;
  localparam int SUM_W      = 10;
  localparam int HIGH_W     = 10;
  localparam int LOW_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_GAP = 3'd6;

  // one classified pixel: GRB word plus latch-gap request
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              gap;
  } entry_t;

endpackage

/* hdl/rgbled_front.sv */
// ----------------------------------------------------------------------------
// rgbled_front
// Accepts pixels, applies gain and optional normalization, and pushes the
// resulting GRB word with its gap flag into the pixel queue.
// ----------------------------------------------------------------------------
module rgbled_front
  import rgbled_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  input  logic              end_of_frame,
  input  logic              latch_request,
  input  logic              normalize_enable,
  input  logic [GAIN_W-1:0] global_gain,
  output logic              q_push,
  output entry_t            q_entry,
  input  logic              q_full
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCALE = 5'b00010,
    S_SETUP = 5'b00100,
    S_DIV   = 5'b01000,
    S_PUSH  = 5'b10000
  } state_t;

  state_t state, state_next;

  // input holding stage
  logic                          hold_valid;
  logic [2:0][CHAN_W-1:0]        hold_ch;    // 0 green, 1 red, 2 blue
  logic                          hold_gap;
  logic                          accept, take;

  // working registers
  logic [2:0][CHAN_W+GAIN_W-1:0] prod;
  logic [2:0][WORD_W-1:0]        num;
  logic [2:0][SUM_W-1:0]         rem;
  logic [2:0][CHAN_W-1:0]        dbits;
  logic [2:0][CHAN_W-1:0]        val;
  logic [2:0]                    satf;
  logic [SUM_W-1:0]              sum;
  logic                          gap;
  logic [2:0]                    step;

  assign take   = hold_valid && (state == S_IDLE);
  assign full   = hold_valid && !take;
  assign accept = push && !full;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_ch[0] <= green;
      hold_ch[1] <= red;
      hold_ch[2] <= blue;
      hold_gap   <= end_of_frame && latch_request;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (hold_valid) state_next = S_SCALE;
      S_SCALE: state_next = normalize_enable ? S_SETUP : S_PUSH;
      S_SETUP: state_next = S_DIV;
      S_DIV:   if (step == 3'd7) state_next = S_PUSH;
      S_PUSH:  if (!q_full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    logic [31:0]   n32;
    logic [SUM_W:0] rsh;
    case (state)
      S_IDLE: begin
        for (int c = 0; c < 3; c++) begin
          prod[c] <= (CHAN_W+GAIN_W)'(hold_ch[c]) * (CHAN_W+GAIN_W)'(global_gain);
        end
        sum  <= SUM_W'(hold_ch[0]) + SUM_W'(hold_ch[1]) + SUM_W'(hold_ch[2]);
        gap  <= hold_gap;
        step <= 3'd0;
      end
      S_SCALE: begin
        for (int c = 0; c < 3; c++) begin
          // x*255 = (x << 8) - x, then drop the 8 fraction bits of the gain
          n32    = {prod[c], 8'h00} - {8'h00, prod[c]};
          num[c] <= n32[31:8];
          satf[c] <= 1'b0;
          val[c]  <= (prod[c][23:16] != 8'h00) ? 8'hFF : prod[c][15:8];
        end
      end
      S_SETUP: begin
        for (int c = 0; c < 3; c++) begin
          satf[c]  <= num[c] >= WORD_W'({sum, 8'h00});
          rem[c]   <= num[c][17:8];
          dbits[c] <= num[c][7:0];
          val[c]   <= 8'h00;
        end
      end
      S_DIV: begin
        // one restoring-division step per channel
        for (int c = 0; c < 3; c++) begin
          rsh = {rem[c], dbits[c][7]};
          if (rsh >= {1'b0, sum}) begin
            rem[c] <= SUM_W'(rsh - {1'b0, sum});
            val[c] <= {val[c][6:0], 1'b1};
          end else begin
            rem[c] <= rsh[SUM_W-1:0];
            val[c] <= {val[c][6:0], 1'b0};
          end
          dbits[c] <= {dbits[c][6:0], 1'b0};
        end
        step <= step + 3'd1;
      end
      default: begin
      end
    endcase
  end

  // final word: black on zero sum, saturation from the setup compare
  always_comb begin
    logic zero_sum;
    zero_sum = normalize_enable && (sum == '0);
    for (int c = 0; c < 3; c++) begin
      q_entry.word[WORD_W-1-CHAN_W*c -: CHAN_W] =
        zero_sum ? 8'h00 : (satf[c] ? 8'hFF : val[c]);
    end
    q_entry.gap = gap;
  end

  assign q_push = (state == S_PUSH) && !q_full;

endmodule

/* hdl/rgbled_queue.sv */
// ----------------------------------------------------------------------------
// rgbled_queue
// Short FIFO of classified pixels between the front and the pulse sequencer.
// ----------------------------------------------------------------------------
module rgbled_queue
  import rgbled_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  entry_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/rgbled_back.sv */
// ----------------------------------------------------------------------------
// rgbled_back
// Pulse sequencer: walks a GRB word MSB first and emits one pulse
// descriptor per bit, plus the latch gap when requested.
// ----------------------------------------------------------------------------
module rgbled_back
  import rgbled_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  entry_t               q_data,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic [TICK_BITS-1:0] one_high_ticks,
  input  logic [TICK_BITS-1:0] one_low_ticks,
  input  logic [TICK_BITS-1:0] zero_high_ticks,
  input  logic [TICK_BITS-1:0] zero_low_ticks,
  input  logic [LOW_W-1:0]     latch_gap_ticks,
  output logic                 empty,
  input  logic                 pop,
  output logic                 bit_value,
  output logic [HIGH_W-1:0]    high_time,
  output logic [LOW_W-1:0]     low_time,
  output logic                 is_gap,
  output logic                 last_pulse
);

  localparam int EXT_W = TICK_BITS + LOW_W;

  // pixel being serialized
  logic              cur_valid;
  logic [WORD_W-1:0] cur_word;
  logic              cur_gap;
  logic [4:0]        cur_idx;
  logic              cur_is_gap, cur_last;
  logic              out_valid, out_load;
  logic [EXT_W-1:0]  hi_ext, lo_ext;

  assign cur_is_gap = (cur_idx == 5'd24);
  assign cur_last   = cur_is_gap || (!cur_gap && cur_idx == 5'd23);
  assign out_load   = cur_valid && (!out_valid || pop);
  assign q_pop      = !q_empty && (!cur_valid || (out_load && cur_last));
  assign empty      = !out_valid;

  assign hi_ext = cur_word[WORD_W-1] ? EXT_W'(one_high_ticks) : EXT_W'(zero_high_ticks);
  assign lo_ext = cur_word[WORD_W-1] ? EXT_W'(one_low_ticks)  : EXT_W'(zero_low_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
    end else if (out_load && cur_last) begin
      cur_valid <= 1'b0;
    end
  end

  // bit walker
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_word <= q_data.word;
      cur_gap  <= q_data.gap;
      cur_idx  <= 5'd0;
    end else if (out_load) begin
      cur_word <= {cur_word[WORD_W-2:0], 1'b0};
      cur_idx  <= cur_idx + 5'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      is_gap     <= cur_is_gap;
      last_pulse <= cur_last;
      if (cur_is_gap) begin
        bit_value <= 1'b0;
        high_time <= '0;
        low_time  <= latch_gap_ticks;
      end else begin
        bit_value <= cur_word[WORD_W-1];
        high_time <= hi_ext[HIGH_W-1:0];
        low_time  <= lo_ext[LOW_W-1:0];
      end
    end
  end

endmodule

/* hdl/rgb_led_serial_transmitter.sv */
// ----------------------------------------------------------------------------
// rgb_led_serial_transmitter
// Turns RGB pixels into single-wire LED pulse descriptors, GRB order,
// MSB first, with an optional latch gap after the last pixel of a frame.
//
//   Channel  Direction  Handshake                Beat
//   pixel    in         push / full              red, green, blue, end_of_frame,
//                                                latch_request
//   pulse    out        pop / empty              bit_value, high_time, low_time,
//                                                is_gap, last_pulse
//   config   in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A pixel passes through the scaling front (scale, then push; with normalization
// on, a setup step and the 8-step restoring divider come between), then waits
// in the queue. The sequencer gives one pulse per cycle while it has a pixel
// and the sink pops: 24 beats per pixel, 25 with a gap. Either side may stall;
// the queue and output register keep them apart. Synchronous reset restores
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "rgb_led_serial_transmitter_macros.svh"

module rgb_led_serial_transmitter
  import rgbled_pkg::*;
#(
  parameter int TICK_BITS   = TICK_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [CHAN_W-1:0]     red,
  input  logic [CHAN_W-1:0]     green,
  input  logic [CHAN_W-1:0]     blue,
  input  logic                  end_of_frame,
  input  logic                  latch_request,
  output logic                  empty,
  input  logic                  pop,
  output logic                  bit_value,
  output logic [HIGH_W-1:0]     high_time,
  output logic [LOW_W-1:0]      low_time,
  output logic                  is_gap,
  output logic                  last_pulse,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic                 normalize_enable;
  logic [GAIN_W-1:0]    global_gain;
  logic [TICK_BITS-1:0] one_high_ticks;
  logic [TICK_BITS-1:0] one_low_ticks;
  logic [TICK_BITS-1:0] zero_high_ticks;
  logic [TICK_BITS-1:0] zero_low_ticks;
  logic [LOW_W-1:0]     latch_gap_ticks;

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      normalize_enable <= 1'b0;
      global_gain      <= GAIN_W'(256);
      one_high_ticks   <= TICK_BITS'(80);
      one_low_ticks    <= TICK_BITS'(30);
      zero_high_ticks  <= TICK_BITS'(30);
      zero_low_ticks   <= TICK_BITS'(80);
      latch_gap_ticks  <= LOW_W'(5000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NORMALIZE: normalize_enable <= cfg_data[0];
        REG_GAIN:      global_gain      <= cfg_data[GAIN_W-1:0];
        REG_ONE_HIGH:  one_high_ticks   <= cfg_data[TICK_BITS-1:0];
        REG_ONE_LOW:   one_low_ticks    <= cfg_data[TICK_BITS-1:0];
        REG_ZERO_HIGH: zero_high_ticks  <= cfg_data[TICK_BITS-1:0];
        REG_ZERO_LOW:  zero_low_ticks   <= cfg_data[TICK_BITS-1:0];
        REG_LATCH_GAP: latch_gap_ticks  <= cfg_data[LOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rgbled_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .end_of_frame     (end_of_frame),
    .latch_request    (latch_request),
    .normalize_enable (normalize_enable),
    .global_gain      (global_gain),
    .q_push           (q_push),
    .q_entry          (q_wdata),
    .q_full           (q_full)
  );

  rgbled_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  rgbled_back #(
    .TICK_BITS (TICK_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_data          (q_rdata),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .one_high_ticks  (one_high_ticks),
    .one_low_ticks   (one_low_ticks),
    .zero_high_ticks (zero_high_ticks),
    .zero_low_ticks  (zero_low_ticks),
    .latch_gap_ticks (latch_gap_ticks),
    .empty           (empty),
    .pop             (pop),
    .bit_value       (bit_value),
    .high_time       (high_time),
    .low_time        (low_time),
    .is_gap          (is_gap),
    .last_pulse      (last_pulse)
  );

  // checks
  `RGBLED_ASSERT_ALWAYS(a_gap_shape, empty || !is_gap || (last_pulse && !bit_value && high_time == '0), "gap beat must be last, low, zero high time")
  `RGBLED_ASSERT_ALWAYS(a_no_push_when_full, !(q_push && q_full), "front pushed into a full queue")
  `RGBLED_ASSERT_NEXT(a_queue_fill, q_push && !q_pop, !q_empty, "queue empty after a push")

endmodule

/* tb/tb_rgb_led_serial_transmitter.sv */
// ----------------------------------------------------------------------------
// tb_rgb_led_serial_transmitter
// Self-checking bench for the serial RGB LED pulse encoder. A directed table
// covers the channel extremes, gain limits, normalization with black input,
// latch handling and tick-register masking. Random phases with new register
// settings follow. Every pulse beat is checked against a typed word or a local
// model of the scaling, in GRB bit order. Both sides idle at random, and the
// sink holds off once for a long time so that the pixel queue backs up.
// ----------------------------------------------------------------------------
module tb_rgb_led_serial_transmitter;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbled_pkg::*;

  localparam int N_DIRECTED      = 35;
  localparam int RAND_PHASES     = 8;
  localparam int PIXELS_PER_PHASE = 24;
  localparam int PRESSURE_PHASE  = 3;
  localparam int HOLD_CYCLES     = 600;
  localparam int TAIL_CYCLES     = 64;
  localparam int MAX_IDLE        = 17;
  localparam longint TIMEOUT_NS  = 5_000_000;

  // index outside the register map, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              eof;
    logic              latch;
  } pixel_t;

  typedef struct packed {
    logic              bit_value;
    logic [HIGH_W-1:0] high_time;
    logic [LOW_W-1:0]  low_time;
    logic              is_gap;
    logic              last_pulse;
  } pulse_t;

  typedef struct {
    logic                         normalize;
    logic [GAIN_W-1:0]            gain;
    logic [TICK_BITS_DEFAULT-1:0] one_high;
    logic [TICK_BITS_DEFAULT-1:0] one_low;
    logic [TICK_BITS_DEFAULT-1:0] zero_high;
    logic [TICK_BITS_DEFAULT-1:0] zero_low;
    logic [LOW_W-1:0]             latch_gap;
  } led_setting_t;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    pixel_t                px;
    logic                  typed;
    logic [WORD_W-1:0]     grb;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
  } row_t;

  // directed table: pixel rows carry a typed GRB word where it is obvious
  localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // reset setting: word is just {g, r, b}
    '{ROW_PIXEL, '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, 24'h000000, '0, '0},
    '{ROW_PIXEL, '{8'hff, 8'hff, 8'hff, 1'b1, 1'b1}, 1'b1, 24'hffffff, '0, '0},
    // latch without end of frame is ignored
    '{ROW_PIXEL, '{8'h12, 8'h34, 8'h56, 1'b0, 1'b1}, 1'b1, 24'h341256, '0, '0},
    '{ROW_PIXEL, '{8'ha5, 8'h5a, 8'hc3, 1'b1, 1'b0}, 1'b1, 24'h5aa5c3, '0, '0},
    '{ROW_PIXEL, '{8'h80, 8'h01, 8'h7f, 1'b1, 1'b1}, 1'b1, 24'h01807f, '0, '0},
    // zero gain
    '{ROW_REG,   '0, 1'b0, '0, REG_GAIN, 16'h0000},
    '{ROW_PIXEL, '{8'hff, 8'hff, 8'hff, 1'b1, 1'b1}, 1'b1, 24'h000000, '0, '0},
    // full gain saturates
    '{ROW_REG,   '0, 1'b0, '0, REG_GAIN, 16'hffff},
    '{ROW_PIXEL, '{8'h01, 8'h01, 8'h01, 1'b0, 1'b0}, 1'b1, 24'hffffff, '0, '0},
    '{ROW_PIXEL, '{8'h00, 8'hff, 8'h00, 1'b1, 1'b1}, 1'b1, 24'hff0000, '0, '0},
    // half gain
    '{ROW_REG,   '0, 1'b0, '0, REG_GAIN, 16'h0080},
    '{ROW_PIXEL, '{8'h03, 8'hff, 8'h80, 1'b0, 1'b0}, 1'b0, '0, '0, '0},
    // normalization, unity gain; black input stays black
    '{ROW_REG,   '0, 1'b0, '0, REG_NORMALIZE, 16'h0001},
    '{ROW_REG,   '0, 1'b0, '0, REG_GAIN, 16'h0100},
    '{ROW_PIXEL, '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1}, 1'b1, 24'h000000, '0, '0},
    '{ROW_PIXEL, '{8'hff, 8'h00, 8'h00, 1'b0, 1'b0}, 1'b1, 24'h00ff00, '0, '0},
    '{ROW_PIXEL, '{8'h10, 8'h20, 8'h30, 1'b1, 1'b1}, 1'b0, '0, '0, '0},
    '{ROW_PIXEL, '{8'hff, 8'hff, 8'hff, 1'b0, 1'b0}, 1'b1, 24'h555555, '0, '0},
    '{ROW_REG,   '0, 1'b0, '0, REG_GAIN, 16'hffff},
    '{ROW_PIXEL, '{8'h01, 8'h02, 8'h03, 1'b1, 1'b0}, 1'b0, '0, '0, '0},
    // tick extremes, zero values and masking of upper data bits
    '{ROW_REG,   '0, 1'b0, '0, REG_ONE_HIGH, 16'h0000},
    '{ROW_REG,   '0, 1'b0, '0, REG_ONE_LOW, 16'h03ff},
    '{ROW_REG,   '0, 1'b0, '0, REG_ZERO_HIGH, 16'hffff},
    '{ROW_REG,   '0, 1'b0, '0, REG_ZERO_LOW, 16'h0000},
    '{ROW_REG,   '0, 1'b0, '0, REG_LATCH_GAP, 16'h0000},
    '{ROW_PIXEL, '{8'ha5, 8'h5a, 8'h0f, 1'b1, 1'b1}, 1'b0, '0, '0, '0},
    '{ROW_REG,   '0, 1'b0, '0, REG_ONE_HIGH, 16'h03ff},
    '{ROW_REG,   '0, 1'b0, '0, REG_ONE_LOW, 16'h0000},
    '{ROW_REG,   '0, 1'b0, '0, REG_ZERO_HIGH, 16'h0001},
    '{ROW_REG,   '0, 1'b0, '0, REG_ZERO_LOW, 16'h0401},
    '{ROW_REG,   '0, 1'b0, '0, REG_LATCH_GAP, 16'hffff},
    '{ROW_REG,   '0, 1'b0, '0, REG_SPARE, 16'hffff},
    '{ROW_REG,   '0, 1'b0, '0, REG_NORMALIZE, 16'h0000},
    '{ROW_REG,   '0, 1'b0, '0, REG_GAIN, 16'h0100},
    '{ROW_PIXEL, '{8'h55, 8'haa, 8'h33, 1'b1, 1'b1}, 1'b1, 24'haa5533, '0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push;
  logic                  full;
  logic [CHAN_W-1:0]     red;
  logic [CHAN_W-1:0]     green;
  logic [CHAN_W-1:0]     blue;
  logic                  end_of_frame;
  logic                  latch_request;
  logic                  empty;
  logic                  pop;
  logic                  bit_value;
  logic [HIGH_W-1:0]     high_time;
  logic [LOW_W-1:0]      low_time;
  logic                  is_gap;
  logic                  last_pulse;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  led_setting_t led_cfg;
  pulse_t       expected_pulses[$];
  int           errors;
  bit           tx_idle_on;
  bit           rx_idle_on;
  bit           rx_hold;
  bit           stall_req;

  rgb_led_serial_transmitter u_top (
    .clk,
    .rst,
    .push,
    .full,
    .red,
    .green,
    .blue,
    .end_of_frame,
    .latch_request,
    .empty,
    .pop,
    .bit_value,
    .high_time,
    .low_time,
    .is_gap,
    .last_pulse,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  // one channel: optional normalization, Q8.8 gain, saturation at 255
  function automatic logic [CHAN_W-1:0] scale_level(logic [CHAN_W-1:0] level,
                                                    logic [SUM_W-1:0] total);
    longint unsigned prod;
    if (led_cfg.normalize && total == 0) return '0;
    if (led_cfg.normalize)
      prod = (longint'(level) * 255 * led_cfg.gain) / (longint'(total) * 256);
    else
      prod = (longint'(level) * led_cfg.gain) >> 8;
    return (prod > 255) ? 8'hff : prod[CHAN_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] scaled_grb(pixel_t p);
    logic [SUM_W-1:0] total;
    total = SUM_W'(p.red) + SUM_W'(p.green) + SUM_W'(p.blue);
    return {scale_level(p.green, total), scale_level(p.red, total),
            scale_level(p.blue, total)};
  endfunction

  // 24 data pulses MSB first, then the optional latch gap
  function automatic void queue_pulses(logic [WORD_W-1:0] grb, logic with_gap);
    pulse_t pl;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      pl.bit_value  = grb[k];
      pl.high_time  = grb[k] ? led_cfg.one_high : led_cfg.zero_high;
      pl.low_time   = grb[k] ? LOW_W'(led_cfg.one_low) : LOW_W'(led_cfg.zero_low);
      pl.is_gap     = 1'b0;
      pl.last_pulse = (k == 0) && !with_gap;
      expected_pulses.push_back(pl);
    end
    if (with_gap) begin
      pl = '{1'b0, '0, led_cfg.latch_gap, 1'b1, 1'b1};
      expected_pulses.push_back(pl);
    end
  endfunction

  // register write; valid stays high so writes can go back to back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_NORMALIZE: led_cfg.normalize = data[0];
      REG_GAIN:      led_cfg.gain      = data;
      REG_ONE_HIGH:  led_cfg.one_high  = data[TICK_BITS_DEFAULT-1:0];
      REG_ONE_LOW:   led_cfg.one_low   = data[TICK_BITS_DEFAULT-1:0];
      REG_ZERO_HIGH: led_cfg.zero_high = data[TICK_BITS_DEFAULT-1:0];
      REG_ZERO_LOW:  led_cfg.zero_low  = data[TICK_BITS_DEFAULT-1:0];
      REG_LATCH_GAP: led_cfg.latch_gap = data;
      default: ;
    endcase
  endtask

  // stop offering pixels and wait for every pending pulse
  task automatic wait_drained();
    push <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk);
  endtask

  // push stays high when the next pixel follows without a gap
  task automatic send_pixel(pixel_t p, logic typed, logic [WORD_W-1:0] grb);
    int unsigned idle;
    idle = tx_idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
    if (idle != 0) begin
      push <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    push          <= 1'b1;
    red           <= p.red;
    green         <= p.green;
    blue          <= p.blue;
    end_of_frame  <= p.eof;
    latch_request <= p.latch;
    do @(posedge clk); while (full);
    queue_pulses(typed ? grb : scaled_grb(p), p.eof & p.latch);
  endtask

  function automatic logic [CHAN_W-1:0] draw_level();
    case ($urandom_range(7, 0))
      0: return 8'h00;
      1: return 8'hff;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_ticks();
    case ($urandom_range(3, 0))
      0: return 16'h0001;
      1: return 16'h03ff;
      2: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1023, 1));
    endcase
  endfunction

  task automatic load_random_setting();
    logic [CFG_DATA_W-1:0] gain;
    logic [CFG_DATA_W-1:0] gap_ticks;
    case ($urandom_range(5, 0))
      0: gain = 16'h0000;
      1: gain = 16'hffff;
      2: gain = 16'h0100;
      3: gain = CFG_DATA_W'($urandom_range(511, 0));
      default: gain = CFG_DATA_W'($urandom);
    endcase
    case ($urandom_range(3, 0))
      0: gap_ticks = 16'h0000;
      1: gap_ticks = 16'hffff;
      default: gap_ticks = CFG_DATA_W'($urandom);
    endcase
    write_reg(REG_NORMALIZE, CFG_DATA_W'($urandom));
    write_reg(REG_GAIN, gain);
    write_reg(REG_ONE_HIGH, draw_ticks());
    write_reg(REG_ONE_LOW, draw_ticks());
    write_reg(REG_ZERO_HIGH, draw_ticks());
    write_reg(REG_ZERO_LOW, draw_ticks());
    write_reg(REG_LATCH_GAP, gap_ticks);
    if ($urandom_range(3, 0) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // compare one popped beat with the oldest expected pulse
  task automatic check_pulse();
    pulse_t want;
    if (expected_pulses.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat bit=%0b high=%0d low=%0d gap=%0b last=%0b",
                              bit_value, high_time, low_time, is_gap, last_pulse));
      return;
    end
    want = expected_pulses.pop_front();
    if (bit_value !== want.bit_value)
      flag_mismatch($sformatf("bit_value got %0b want %0b", bit_value, want.bit_value));
    if (high_time !== want.high_time)
      flag_mismatch($sformatf("high_time got %0d want %0d", high_time, want.high_time));
    if (low_time !== want.low_time)
      flag_mismatch($sformatf("low_time got %0d want %0d", low_time, want.low_time));
    if (is_gap !== want.is_gap)
      flag_mismatch($sformatf("is_gap got %0b want %0b", is_gap, want.is_gap));
    if (last_pulse !== want.last_pulse)
      flag_mismatch($sformatf("last_pulse got %0b want %0b", last_pulse, want.last_pulse));
  endtask

  // pulse sink: random gaps per beat, plus the long hold-off
  initial begin
    int unsigned idle;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      idle = rx_idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
      if (idle != 0 || rx_hold) begin
        pop <= 1'b0;
        repeat (idle) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_pulse();
    end
  end

  // long sink stall, counted here so the sender keeps running
  initial begin
    rx_hold = 1'b0;
    wait (stall_req);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // main sequence
  initial begin
    row_t step;
    push          = 1'b0;
    red           = '0;
    green         = '0;
    blue          = '0;
    end_of_frame  = 1'b0;
    latch_request = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    errors        = 0;
    stall_req     = 1'b0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    led_cfg       = '{1'b0, 16'd256, 10'd80, 10'd30, 10'd30, 10'd80, 16'd5000};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      step = DIRECTED_ROWS[i];
      if (step.kind == ROW_REG) begin
        wait_drained();
        write_reg(step.reg_idx, step.reg_data);
      end else begin
        if (i > 0 && DIRECTED_ROWS[i-1].kind == ROW_REG) cfg_valid <= 1'b0;
        send_pixel(step.px, step.typed, step.grb);
      end
    end

    // random phases, each with a fresh register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      load_random_setting();
      tx_idle_on = ($urandom_range(3, 0) != 0);
      rx_idle_on = ($urandom_range(3, 0) != 0);
      if (ph == PRESSURE_PHASE) begin
        tx_idle_on = 1'b0;
        stall_req  = 1'b1;
      end
      repeat (PIXELS_PER_PHASE)
        send_pixel('{draw_level(), draw_level(), draw_level(),
                     ($urandom_range(3, 0) == 0), 1'($urandom)}, 1'b0, '0);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/rgbled_pkg.sv
hdl/rgbled_front.sv
hdl/rgbled_queue.sv
hdl/rgbled_back.sv
hdl/rgb_led_serial_transmitter.sv
tb/tb_rgb_led_serial_transmitter.sv
